### hdl/ttpf_pkg.sv
package ttpf_pkg;

    localparam int TAG_LIMIT_DEF = 6;

    // Characters the tag parser looks for
    localparam logic [7:0] CH_MARK  = 8'h24;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Tag lengths including both marks: "$X$" and "$/X$"
    localparam int TAG_LEN_SHORT = 3;
    localparam int TAG_LEN_LONG  = 4;

    localparam logic [15:0] TAG_PAUSE_RST     = 16'd750;
    localparam logic [15:0] TYPING_PAUSE_RST  = 16'd100;
    localparam logic [15:0] NEWLINE_PAUSE_RST = 16'd200;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAG_PAUSE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPING_PAUSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_PAUSE = 2'd2;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_PAUSE = 1'b1;

    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_TYPE,
        SEL_NL,
        SEL_DELAY,
        SEL_FLUSH
    } sel_t;

    typedef struct packed {
        logic accept;
        logic load;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic plain;
        logic delay;
        logic flush;
        logic typ;
        logic nl;
        logic flush_end;
    } stat_t;

endpackage

### hdl/ttpf_dp.sv
module ttpf_dp
    import ttpf_pkg::*;
#(
    parameter int TAG_LIMIT = TAG_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            in_char,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [7:0]            out_char,
    output logic [15:0]           pause_len,
    output logic                  last
);

    localparam int CNT_W = $clog2(TAG_LIMIT + 1);
    localparam int IDX_W = $clog2(TAG_LIMIT);

    logic [7:0]       tag_mem [TAG_LIMIT];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             typing_reg, typing_next;
    logic             skip_reg, skip_next;
    logic             typ_reg, nl_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       char_reg;
    logic [15:0]      tag_pause_reg, typing_pause_reg, newline_pause_reg;

    logic             out_valid_reg;
    logic             kind_reg, kind_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic [15:0]      pause_len_reg, pause_len_next;
    logic             last_reg;

    logic             in_tag, is_mark, plain, close, flush, delay, typ_now, nl_now;
    logic [CNT_W-1:0] cnt_inc;

    assign in_tag  = count_reg != '0;
    assign is_mark = in_char == CH_MARK;
    assign cnt_inc = count_reg + 1'b1;
    assign plain   = !in_tag && !is_mark;
    assign close   = in_tag && is_mark;
    assign flush   = in_tag && !is_mark && (cnt_inc == CNT_W'(TAG_LIMIT));
    assign delay   = close && (cnt_inc == CNT_W'(TAG_LEN_SHORT)) && (tag_mem[1] == CH_D);
    assign typ_now = plain && !skip_reg && typing_reg && (in_char != CH_NUL);
    assign nl_now  = plain && !skip_reg && (in_char == CH_NL);

    assign stat.slot_free = !out_valid_reg || !out_stall;
    assign stat.plain     = plain;
    assign stat.delay     = delay;
    assign stat.flush     = flush;
    assign stat.typ       = typ_reg;
    assign stat.nl        = nl_reg;
    assign stat.flush_end = idx_reg == IDX_W'(TAG_LIMIT - 1);

    always_comb
    begin
        count_next  = count_reg;
        typing_next = typing_reg;
        skip_next   = skip_reg;
        if (!in_tag)
        begin
            if (is_mark)
                count_next = CNT_W'(1);
        end
        else if (close || flush)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = cnt_inc;
        end
        // Mode tags take effect on the closing mark
        if (close && (cnt_inc == CNT_W'(TAG_LEN_SHORT)))
        begin
            if (tag_mem[1] == CH_T)
                typing_next = 1'b1;
            else if (tag_mem[1] == CH_S)
                skip_next = 1'b1;
        end
        else if (close && (cnt_inc == CNT_W'(TAG_LEN_LONG)) && (tag_mem[1] == CH_SLASH))
        begin
            if (tag_mem[2] == CH_T)
                typing_next = 1'b0;
            else if (tag_mem[2] == CH_S)
                skip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            typing_reg        <= 1'b0;
            skip_reg          <= 1'b0;
            typ_reg           <= 1'b0;
            nl_reg            <= 1'b0;
            idx_reg           <= '0;
            tag_pause_reg     <= TAG_PAUSE_RST;
            typing_pause_reg  <= TYPING_PAUSE_RST;
            newline_pause_reg <= NEWLINE_PAUSE_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                count_reg  <= count_next;
                typing_reg <= typing_next;
                skip_reg   <= skip_next;
                typ_reg    <= typ_now;
                nl_reg     <= nl_now;
                idx_reg    <= '0;
            end
            else if (cmd.load && (cmd.sel == SEL_FLUSH))
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TAG_PAUSE:     tag_pause_reg     <= cfg_data;
                    REG_TYPING_PAUSE:  typing_pause_reg  <= cfg_data;
                    REG_NEWLINE_PAUSE: newline_pause_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Tag buffer and item payload carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg <= in_char;
            if (in_tag || is_mark)
                tag_mem[count_reg[IDX_W-1:0]] <= in_char;
        end
        if (cmd.load)
        begin
            kind_reg      <= kind_next;
            out_char_reg  <= out_char_next;
            pause_len_reg <= pause_len_next;
            last_reg      <= cmd.last;
        end
    end

    always_comb
    begin
        kind_next      = KIND_PAUSE;
        out_char_next  = 8'h00;
        pause_len_next = 16'h0000;
        case (cmd.sel)
            SEL_BYTE:
            begin
                kind_next     = KIND_BYTE;
                out_char_next = char_reg;
            end
            SEL_FLUSH:
            begin
                kind_next     = KIND_BYTE;
                out_char_next = tag_mem[idx_reg];
            end
            SEL_TYPE:  pause_len_next = typing_pause_reg;
            SEL_NL:    pause_len_next = newline_pause_reg;
            SEL_DELAY: pause_len_next = tag_pause_reg;
            default:   pause_len_next = 16'h0000;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_char  = out_char_reg;
    assign pause_len = pause_len_reg;
    assign last      = last_reg;

endmodule

### hdl/ttpf_ctrl.sv
module ttpf_ctrl
    import ttpf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BYTE  = 6'b000010,
        ST_TYPE  = 6'b000100,
        ST_NL    = 6'b001000,
        ST_DELAY = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.sel    = SEL_BYTE;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (stat.plain)
                        state_next = ST_BYTE;
                    else if (stat.delay)
                        state_next = ST_DELAY;
                    else if (stat.flush)
                        state_next = ST_FLUSH;
                end
            end
            ST_BYTE:
            begin
                cmd.sel  = SEL_BYTE;
                cmd.last = !stat.typ && !stat.nl;
                if (stat.slot_free)
                begin
                    cmd.load = 1'b1;
                    if (stat.typ)
                        state_next = ST_TYPE;
                    else if (stat.nl)
                        state_next = ST_NL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_TYPE:
            begin
                cmd.sel  = SEL_TYPE;
                cmd.last = !stat.nl;
                if (stat.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.nl ? ST_NL : ST_IDLE;
                end
            end
            ST_NL:
            begin
                cmd.sel  = SEL_NL;
                cmd.last = 1'b1;
                if (stat.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DELAY:
            begin
                cmd.sel  = SEL_DELAY;
                cmd.last = 1'b1;
                if (stat.slot_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                cmd.sel  = SEL_FLUSH;
                cmd.last = stat.flush_end;
                if (stat.slot_free)
                begin
                    cmd.load = 1'b1;
                    if (stat.flush_end)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

### hdl/text_tag_pacing_filter.sv
// The first result of an item is loaded in the state entered on acceptance, then
// registered on the output. The sequencer loads one result per cycle while the output
// slot is free; the next item is taken once the last result is loaded (tag pause,
// plain byte and its pauses, raw tag buffer flush); a buffered tag byte loads none.
// Reset clears tag count, modes, control and output valid; the pause registers
// return to 750, 100 and 200 ms. The tag buffer is not cleared.
module text_tag_pacing_filter
    import ttpf_pkg::*;
#(
    parameter int TAG_LIMIT = TAG_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [7:0]            out_char,
    output logic [15:0]           pause_len,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    ttpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttpf_dp #(
        .TAG_LIMIT (TAG_LIMIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (in_char),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_char  (out_char),
        .pause_len (pause_len),
        .last      (last)
    );

endmodule

### hdl/ttpf_checker.sv
module ttpf_checker
    import ttpf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [7:0]            in_char,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  kind,
    input logic [7:0]            out_char,
    input logic [15:0]           pause_len,
    input logic                  last,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // Stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_char)
            && $stable(pause_len) && $stable(last))
        else $error("stalled output item changed");

    // Pauses carry no byte
    a_pause_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAUSE) |-> out_char == 8'h00)
        else $error("pause item with nonzero byte");

    // Bytes carry no pause length
    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) |-> pause_len == 16'h0000)
        else $error("byte item with nonzero pause length");

    // No new item while results of the current one are still pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input accepted before last result of previous item");

endmodule

bind text_tag_pacing_filter ttpf_checker u_ttpf_checker (.*);
